[sv/efsd_pkg.sv]
`default_nettype none

package efsd_pkg;

	localparam int MAX_SERVERS = 4;
	localparam int MAX_JOBS    = 1024;

	localparam int DUR_W = 16;
	localparam int REM_W = DUR_W + 1;
	localparam int SRV_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int JOB_W = $clog2(MAX_JOBS);
	localparam int CFG_W = 3;

	localparam logic [CFG_W-1:0] SERVERS_RESET = CFG_W'(4);

	// Register select is bit 2 of the byte address.
	localparam logic REG_SERVERS_IN_USE = 1'b0;

	typedef struct packed {
		logic                    have;
		logic signed [REM_W-1:0] rem;
		logic [SRV_W-1:0]        idx;
		logic [JOB_W-1:0]        cnt;
	} efsd_link_t;

	function automatic logic [JOB_W-1:0] efsd_next_job(input logic [JOB_W-1:0] cnt);
		logic [JOB_W-1:0] nxt;
		if (cnt == JOB_W'(MAX_JOBS - 1)) begin
			nxt = '0;
		end else begin
			nxt = cnt + 1'b1;
		end
		return nxt;
	endfunction

endpackage

`default_nettype wire

[sv/efsd_cell.sv]
`default_nettype none

module efsd_cell
	import efsd_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [SRV_W-1:0]        cell_id,
	input  wire logic                    active,
	input  wire logic                    sub_en,
	input  wire logic                    load_en,
	input  wire logic signed [REM_W-1:0] dur,
	input  wire efsd_link_t              link_in,
	output efsd_link_t                   link_out,
	output logic                         nonpos
);

	logic signed [REM_W-1:0] rem_q;
	logic [JOB_W-1:0]        cnt_q;
	efsd_link_t              link_q;
	logic                    take_mine;

	assign nonpos    = active && (rem_q <= 0);
	assign take_mine = active && (!link_in.have || (rem_q < link_in.rem));
	assign link_out  = link_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			cnt_q <= '0;
		end else if (load_en) begin
			rem_q <= dur;
			cnt_q <= efsd_next_job(cnt_q);
		end else if (sub_en && active) begin
			rem_q <= rem_q - dur;
		end
	end

	// The running minimum moves one cell down the row per clock.
	always_ff @(posedge clk) begin
		if (take_mine) begin
			link_q.have <= 1'b1;
			link_q.rem  <= rem_q;
			link_q.idx  <= cell_id;
			link_q.cnt  <= cnt_q;
		end else begin
			link_q <= link_in;
		end
	end

endmodule

`default_nettype wire

[sv/earliest_free_server_dispatch_unit.sv]
`default_nettype none

// Channel   Direction  Handshake                  Payload
// job       in         job_valid / job_stall      job_duration
// result    out        result_valid / result_stall server_index, job_number, slot_index
// config    in         APB psel/penable/pready    paddr, pwdata, prdata
//
// From acceptance to the next acceptance a job passes the subtraction, scan and
// load steps; subtraction rounds repeat until an active server's remaining time
// is zero or less (none when a server is already free or the duration is zero).
// The minimum search walks the row of server cells, one cell per cycle.
// Reset clears all counters and sets four servers in use; no clearing pass.
// A stalled result holds the block in its load step only once a new job is in.

module earliest_free_server_dispatch_unit
	import efsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              job_valid,
	output logic                   job_stall,
	input  wire logic [DUR_W-1:0]  job_duration,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic [SRV_W-1:0]       server_index,
	output logic [JOB_W-1:0]       job_number,
	output logic [JOB_W-1:0]       slot_index,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SUB  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_LOAD = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [CFG_W-1:0]        servers_q;
	logic [CFG_W-1:0]        n_active;
	logic [DUR_W-1:0]        dur_q;
	logic [SRV_W-1:0]        scan_q;
	logic [JOB_W-1:0]        job_cnt_q;
	logic                    res_valid_q;
	logic [SRV_W-1:0]        res_idx_q;
	logic [JOB_W-1:0]        res_job_q;
	logic [JOB_W-1:0]        res_slot_q;

	logic [MAX_SERVERS-1:0]  active;
	logic [MAX_SERVERS-1:0]  nonpos;
	logic [MAX_SERVERS-1:0]  load_sel;
	efsd_link_t              link [MAX_SERVERS+1];
	efsd_link_t              best;
	logic signed [REM_W-1:0] dur_ext;
	logic                    any_free;
	logic                    sub_en;
	logic                    load_go;
	logic                    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SERVERS_IN_USE);
	assign prdata = (paddr[2] == REG_SERVERS_IN_USE) ? 32'(servers_q) : '0;

	always_comb begin
		if (servers_q == '0) begin
			n_active = CFG_W'(1);
		end else if (32'(servers_q) > MAX_SERVERS) begin
			n_active = CFG_W'(MAX_SERVERS);
		end else begin
			n_active = servers_q;
		end
	end

	assign dur_ext  = signed'({1'b0, dur_q});
	assign any_free = |nonpos;
	assign sub_en   = (state_q == ST_SUB) && (dur_q != '0) && !any_free;
	assign load_go  = (state_q == ST_LOAD) && (!res_valid_q || !result_stall);
	assign best     = link[MAX_SERVERS];

	assign link[0] = '0;

	for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
		assign active[i]   = 32'(n_active) > i;
		assign load_sel[i] = load_go && (best.idx == SRV_W'(i));

		efsd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_id  (SRV_W'(i)),
			.active   (active[i]),
			.sub_en   (sub_en),
			.load_en  (load_sel[i]),
			.dur      (dur_ext),
			.link_in  (link[i]),
			.link_out (link[i+1]),
			.nonpos   (nonpos[i])
		);
	end

	assign job_stall    = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign server_index = res_idx_q;
	assign job_number   = res_job_q;
	assign slot_index   = res_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servers_q <= SERVERS_RESET;
		end else if (cfg_wr) begin
			servers_q <= pwdata[CFG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			job_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_go) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					if (!sub_en) begin
						state_q <= ST_SCAN;
						scan_q  <= '0;
					end
				end
				ST_SCAN: begin
					if (scan_q == SRV_W'(MAX_SERVERS - 1)) begin
						state_q <= ST_LOAD;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_LOAD: begin
					if (load_go) begin
						state_q   <= ST_IDLE;
						job_cnt_q <= efsd_next_job(job_cnt_q);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			dur_q <= job_duration;
		end
		if (load_go) begin
			res_idx_q  <= best.idx;
			res_job_q  <= job_cnt_q;
			res_slot_q <= best.cnt;
		end
	end

	a_zero_dur_no_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUB && dur_q == '0) |=> (state_q == ST_SCAN))
		else $error("zero duration did not leave the subtraction step");

	a_best_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (best.have && active[best.idx]))
		else $error("chosen server is not an active server");

	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(load_go))
		else $error("result appeared without a load step");

	a_job_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		load_go |=> (job_cnt_q == efsd_next_job($past(job_cnt_q))))
		else $error("job counter did not advance on dispatch");

	a_sub_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sub_en |-> (!any_free && job_stall))
		else $error("subtraction round while a server is free");

endmodule

`default_nettype wire

[dv/earliest_free_server_dispatch_unit_tb.sv]
module earliest_free_server_dispatch_unit_tb;
	import efsd_pkg::*;

	localparam int ROUND_CAP     = 256;
	localparam int SETTLE_CYCLES = MAX_SERVERS + 12;

	typedef enum int {DUR_WIDE, DUR_NARROW} dur_mode_t;
	typedef enum int {RX_OPEN, RX_SPARSE, RX_HEAVY} rx_mode_t;

	typedef struct packed {
		logic [SRV_W-1:0] server;
		logic [JOB_W-1:0] job;
		logic [JOB_W-1:0] slot;
	} assignment_t;

	class server_ledger;
		logic signed [REM_W-1:0] remaining [MAX_SERVERS];
		logic [JOB_W-1:0]        served [MAX_SERVERS];
		logic [JOB_W-1:0]        next_job;
		logic [CFG_W-1:0]        servers_cfg;
		assignment_t             due[$];
		int                      errors;

		function new();
			for (int i = 0; i < MAX_SERVERS; i++) begin
				remaining[i] = '0;
				served[i] = '0;
			end
			next_job = '0;
			servers_cfg = SERVERS_RESET;
			errors = 0;
		endfunction

		function int active_count();
			if (servers_cfg == 0) begin
				return 1;
			end
			if (servers_cfg > MAX_SERVERS) begin
				return MAX_SERVERS;
			end
			return int'(servers_cfg);
		endfunction

		function void find_lowest(output int best, output int low);
			best = 0;
			low = int'(remaining[0]);
			for (int i = 1; i < active_count(); i++) begin
				if (int'(remaining[i]) < low) begin
					low = int'(remaining[i]);
					best = i;
				end
			end
		endfunction

		// Keeps the number of subtraction rounds per job within a sane budget.
		function logic [DUR_W-1:0] bounded(input logic [DUR_W-1:0] dur_req);
			int best;
			int low;
			int d;
			d = int'(dur_req);
			find_lowest(best, low);
			if (d > 0 && low > 0 && (low + d - 1) / d > ROUND_CAP) begin
				return DUR_W'($urandom_range(2**DUR_W - 1, (low + ROUND_CAP - 1) / ROUND_CAP));
			end
			return dur_req;
		endfunction

		function void log_job(input logic [DUR_W-1:0] dur);
			int best;
			int low;
			int d;
			int total;
			d = int'(dur);
			find_lowest(best, low);
			if (low > 0 && d > 0) begin
				total = ((low + d - 1) / d) * d;
				for (int i = 0; i < active_count(); i++) begin
					remaining[i] = REM_W'(int'(remaining[i]) - total);
				end
			end
			remaining[best] = REM_W'(d);
			due.push_back('{server: SRV_W'(best), job: next_job, slot: served[best]});
			next_job = next_job + 1'b1;
			served[best] = served[best] + 1'b1;
		endfunction

		function void check_assignment(input logic [SRV_W-1:0] server,
				input logic [JOB_W-1:0] job, input logic [JOB_W-1:0] slot);
			assignment_t exp_a;
			if (due.size() == 0) begin
				$error("Result transaction with no job waiting: server_index %0d", server);
				errors++;
				return;
			end
			exp_a = due.pop_front();
			if (server !== exp_a.server) begin
				$error("server_index: expected %0d, got %0d", exp_a.server, server);
				errors++;
			end
			if (job !== exp_a.job) begin
				$error("job_number: expected %0d, got %0d", exp_a.job, job);
				errors++;
			end
			if (slot !== exp_a.slot) begin
				$error("slot_index: expected %0d, got %0d", exp_a.slot, slot);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             job_valid;
	logic             job_stall;
	logic [DUR_W-1:0] job_duration;
	logic             result_valid;
	logic             result_stall;
	logic [SRV_W-1:0] server_index;
	logic [JOB_W-1:0] job_number;
	logic [JOB_W-1:0] slot_index;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [2:0]       paddr;
	logic [31:0]      pwdata;
	logic [31:0]      prdata;
	logic             pready;

	server_ledger ledger = new();
	int           burst_left = 0;
	rx_mode_t     rx_mode = RX_OPEN;
	int           rx_left = 0;

	earliest_free_server_dispatch_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job_stall    (job_stall),
		.job_duration (job_duration),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.server_index (server_index),
		.job_number   (job_number),
		.slot_index   (slot_index),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(2));
			rx_left = $urandom_range(80, 8);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: begin
				result_stall = 1'b0;
			end
			RX_SPARSE: begin
				result_stall = ($urandom_range(3) == 0);
			end
			default: begin
				result_stall = ($urandom_range(3) != 0);
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			ledger.check_assignment(server_index, job_number, slot_index);
		end
	end

	function automatic logic [DUR_W-1:0] pick_duration(input dur_mode_t mode);
		int sel;
		sel = $urandom_range(99);
		if (mode == DUR_NARROW) begin
			return DUR_W'($urandom_range(8, 1));
		end
		if (sel < 40) begin
			return DUR_W'($urandom());
		end else if (sel < 65) begin
			return DUR_W'($urandom_range(64, 1));
		end else if (sel < 85) begin
			return DUR_W'($urandom_range(4096, 65));
		end else if (sel < 90) begin
			return '0;
		end else if (sel < 95) begin
			return '1;
		end
		return DUR_W'(1);
	endfunction

	task automatic send_job(input logic [DUR_W-1:0] dur_req);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = $urandom_range(6);
			if (gap != 0) begin
				job_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(7) == 0) ? 48 : $urandom_range(12, 1);
		end
		job_duration = ledger.bounded(dur_req);
		job_valid = 1'b1;
		do @(posedge clk); while (job_stall);
		ledger.log_job(job_duration);
		burst_left--;
	endtask

	task automatic end_burst();
		@(negedge clk);
		job_valid = 1'b0;
		burst_left = 0;
	endtask

	task automatic wait_idle();
		while (ledger.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_servers(input logic [CFG_W-1:0] value);
		wait_idle();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {REG_SERVERS_IN_USE, 2'b00};
		pwdata = ($urandom() & ~32'h7) | 32'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		ledger.servers_cfg = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_list(input logic [DUR_W-1:0] durs[]);
		foreach (durs[i]) begin
			send_job(durs[i]);
		end
		end_burst();
	endtask

	task automatic run_random(input int count, input dur_mode_t mode);
		repeat (count) begin
			send_job(pick_duration(mode));
		end
		end_burst();
	endtask

	initial begin
		arst_n = 1'b0;
		job_valid = 1'b0;
		job_duration = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_list('{16'hFFFF, 16'd1, 16'd0, 16'h8000, 16'd1, 16'd2, 16'd0, 16'h5555,
			16'hAAAA, 16'd300, 16'd7, 16'hFFFF});
		write_servers(3'd1);
		send_list('{16'd100, 16'd1, 16'hFFFF, 16'd3});
		write_servers(3'd0);
		send_list('{16'd5, 16'd0, 16'd2});
		write_servers(3'd7);
		send_list('{16'hFFFF, 16'd9, 16'd1});

		foreach (ledger.remaining[i]) begin
			case (i)
				0: write_servers(3'd5);
				1: write_servers(3'd2);
				2: write_servers(3'd3);
				default: write_servers(3'd6);
			endcase
			run_random(100, DUR_WIDE);
		end
		write_servers(3'd1);
		run_random(280, DUR_NARROW);
		write_servers(3'd4);
		run_random(50, DUR_WIDE);

		wait_idle();
		if (ledger.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
